### rtl/sip_pkg.sv
package sip_pkg;

  localparam logic [63:0] IV0 = 64'h736f6d6570736575;
  localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
  localparam logic [63:0] IV2 = 64'h6c7967656e657261;
  localparam logic [63:0] IV3 = 64'h7465646279746573;
  localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;
  localparam int LEN_SHIFT = 56;
  localparam int FIN_ROUNDS = 4;

  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  typedef logic [3:0][63:0] sip_lanes_t;

  typedef struct packed {
    logic [63:0] block;
    logic        last;
  } sip_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND2,
    ST_FINAL
  } sip_state_t;

  function automatic sip_lanes_t sip_init(input logic [63:0] k0, input logic [63:0] k1);
    sip_lanes_t v;
    v[0] = IV0 ^ k0;
    v[1] = IV1 ^ k1;
    v[2] = IV2 ^ k0;
    v[3] = IV3 ^ k1;
    return v;
  endfunction

  function automatic sip_lanes_t sip_round(input sip_lanes_t v);
    logic [63:0] a, b, c, d;
    sip_lanes_t r;
    a = v[0];
    b = v[1];
    c = v[2];
    d = v[3];
    a = a + b; b = {b[50:0], b[63:51]}; b = b ^ a; a = {a[31:0], a[63:32]};
    c = c + d; d = {d[47:0], d[63:48]}; d = d ^ c;
    a = a + d; d = {d[42:0], d[63:43]}; d = d ^ a;
    c = c + b; b = {b[46:0], b[63:47]}; b = b ^ c; c = {c[31:0], c[63:32]};
    r[0] = a;
    r[1] = b;
    r[2] = c;
    r[3] = d;
    return r;
  endfunction

endpackage

### rtl/sip_queue.sv
module sip_queue import sip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sip_item_t item_in,
  input  logic      pop,
  output sip_item_t item_out,
  output logic      full,
  output logic      empty
);

  sip_item_t mem [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign item_out = mem[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= item_in;
    end
  end

endmodule

### rtl/sip_front.sv
module sip_front import sip_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [63:0] in_message_word,
  input  logic [2:0]  in_tail_count,
  input  logic        in_final_item,
  input  logic        q_full,
  output logic        q_push,
  output sip_item_t   q_item
);

  logic [7:0]  len_r, len_nxt;
  logic [7:0]  total;
  logic [63:0] mask;

  assign q_push = in_push && !q_full;
  assign total  = len_r + {5'd0, in_tail_count};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[i*8 +: 8] = (3'(i) < in_tail_count) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    q_item.last = in_final_item;
    if (in_final_item) begin
      q_item.block = ({56'd0, total} << LEN_SHIFT) | (in_message_word & mask);
    end else begin
      q_item.block = in_message_word;
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (q_push) begin
      len_nxt = in_final_item ? 8'd0 : len_r + 8'd8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 8'd0;
    end else begin
      len_r <= len_nxt;
    end
  end

endmodule

### rtl/sip_back.sv
module sip_back import sip_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  input  logic        q_empty,
  input  sip_item_t   q_item,
  output logic        q_pop,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [63:0] out_digest
);

  sip_state_t  state_r, state_nxt;
  sip_lanes_t  lanes_r, lanes_nxt;
  logic [63:0] blk_r, blk_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  rnd_r, rnd_nxt;
  logic        in_msg_r, in_msg_nxt;

  logic [63:0] oq_mem [2];
  logic        oq_wr_r, oq_rd_r;
  logic [1:0]  oq_cnt_r, oq_cnt_nxt;
  logic        oq_push, oq_pop, oq_full;

  sip_lanes_t  base, rnd_in, rnd_out;
  logic [63:0] digest;

  assign oq_full    = (oq_cnt_r == 2'd2);
  assign out_empty  = (oq_cnt_r == 2'd0);
  assign out_digest = oq_mem[oq_rd_r];
  assign oq_pop     = out_pop && !out_empty;

  assign rnd_out = sip_round(rnd_in);
  assign digest  = rnd_out[0] ^ rnd_out[1] ^ rnd_out[2] ^ rnd_out[3];

  always_comb begin
    base    = in_msg_r ? lanes_r : sip_init(key_low, key_high);
    base[3] = base[3] ^ q_item.block;
    rnd_in  = (state_r == ST_IDLE) ? base : lanes_r;
  end

  always_comb begin
    state_nxt  = state_r;
    lanes_nxt  = lanes_r;
    blk_nxt    = blk_r;
    last_nxt   = last_r;
    rnd_nxt    = rnd_r;
    in_msg_nxt = in_msg_r;
    q_pop      = 1'b0;
    oq_push    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty && (!q_item.last || !oq_full)) begin
          q_pop      = 1'b1;
          lanes_nxt  = rnd_out;
          blk_nxt    = q_item.block;
          last_nxt   = q_item.last;
          in_msg_nxt = 1'b1;
          state_nxt  = ST_ROUND2;
        end
      end
      ST_ROUND2: begin
        lanes_nxt    = rnd_out;
        lanes_nxt[0] = rnd_out[0] ^ blk_r;
        rnd_nxt      = 2'd0;
        if (last_r) begin
          lanes_nxt[2] = rnd_out[2] ^ FIN_XOR;
          state_nxt    = ST_FINAL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FINAL: begin
        lanes_nxt = rnd_out;
        rnd_nxt   = rnd_r + 2'd1;
        if (rnd_r == 2'(FIN_ROUNDS - 1)) begin
          oq_push    = 1'b1;
          in_msg_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 2'd1;
    end else if (oq_pop && !oq_push) begin
      oq_cnt_nxt = oq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      in_msg_r <= 1'b0;
      rnd_r    <= 2'd0;
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      in_msg_r <= in_msg_nxt;
      rnd_r    <= rnd_nxt;
      oq_wr_r  <= oq_push ? ~oq_wr_r : oq_wr_r;
      oq_rd_r  <= oq_pop ? ~oq_rd_r : oq_rd_r;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lanes_r <= lanes_nxt;
    blk_r   <= blk_nxt;
    last_r  <= last_nxt;
    if (oq_push) begin
      oq_mem[oq_wr_r] <= digest;
    end
  end

endmodule

### rtl/siphash_2_4_keyed_hash.sv
// Channel   Ports                                              Handshake
// input     in_message_word, in_tail_count, in_final_item      in_push / in_full
// result    out_digest                                         out_empty / out_pop
// config    cfg_index, cfg_wdata                               cfg_we
//
// One SipRound per cycle through a single round unit unless it waits for work:
// a word takes 2 rounds, a final word 6 (2 compression + 4 finalization rounds).
// A 2-entry queue sits between input classification and the round engine;
// a 2-entry queue holds digests, so two can wait on out_pop before input stalls.
// In idle, the engine holds a final word in the queue only if the digest queue is full.
// Reset is synchronous, active low; keys reset to zero.
module siphash_2_4_keyed_hash import sip_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_message_word,
  input  logic [2:0]  in_tail_count,
  input  logic        in_final_item,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_digest
);

  logic [63:0] key_low_r, key_high_r;
  logic        q_push, q_pop, q_full, q_empty;
  sip_item_t   q_in, q_out;

  assign in_full = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= 64'd0;
      key_high_r <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        REG_KEY_HIGH: key_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sip_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_message_word (in_message_word),
    .in_tail_count   (in_tail_count),
    .in_final_item   (in_final_item),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_in)
  );

  sip_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .item_in  (q_in),
    .pop      (q_pop),
    .item_out (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  sip_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_low    (key_low_r),
    .key_high   (key_high_r),
    .q_empty    (q_empty),
    .q_item     (q_out),
    .q_pop      (q_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_digest (out_digest)
  );

`ifndef SYNTHESIS
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_empty && q_full))
    else $error("word queue both empty and full");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> (out_empty && !in_full))
    else $error("queues not empty after reset");

  a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("round engine took a word from an empty queue");
`endif

endmodule

### tb/sv/siphash_2_4_keyed_hash_checker.sv
`timescale 1ns / 100ps

module siphash_2_4_keyed_hash_checker import sip_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [63:0] in_message_word,
  input  logic [2:0]  in_tail_count,
  input  logic        in_final_item,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [63:0] out_digest,
  input  logic        drain_done,
  output int          fail_count,
  output int          digest_count
);

  localparam logic [63:0] INIT0 = 64'h736f6d6570736575;
  localparam logic [63:0] INIT1 = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT2 = 64'h6c7967656e657261;
  localparam logic [63:0] INIT3 = 64'h7465646279746573;
  localparam logic [63:0] FINAL_FLIP = 64'h00000000000000ff;

  sip_lanes_t  lanes;
  logic [7:0]  byte_len;
  bit          mid_message;
  logic [63:0] key_lo;
  logic [63:0] key_hi;
  logic [63:0] digest_q[$];
  int          fails;
  int          shown;
  bit          drained;

  assign fail_count = fails;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic sip_lanes_t mix_round(input sip_lanes_t v);
    logic [63:0] a, b, c, d;
    a = v[0];
    b = v[1];
    c = v[2];
    d = v[3];
    a = a + b; b = rotl64(b, 13); b = b ^ a; a = rotl64(a, 32);
    c = c + d; d = rotl64(d, 16); d = d ^ c;
    a = a + d; d = rotl64(d, 21); d = d ^ a;
    c = c + b; b = rotl64(b, 17); b = b ^ c; c = rotl64(c, 32);
    return {d, c, b, a};
  endfunction

  function automatic sip_lanes_t compress(input sip_lanes_t v, input logic [63:0] m);
    v[3] = v[3] ^ m;
    v = mix_round(mix_round(v));
    v[0] = v[0] ^ m;
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      key_lo = '0;
      key_hi = '0;
      mid_message = 0;
      byte_len = '0;
      digest_q.delete();
      fails = 0;
      shown = 0;
      drained = 0;
      digest_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_KEY_LOW) key_lo = cfg_wdata;
        else key_hi = cfg_wdata;
      end

      if (in_push && !in_full) begin : predict
        logic [63:0] mask;
        logic [7:0]  total;
        if (!mid_message) begin
          lanes[0] = INIT0 ^ key_lo;
          lanes[1] = INIT1 ^ key_hi;
          lanes[2] = INIT2 ^ key_lo;
          lanes[3] = INIT3 ^ key_hi;
          byte_len = '0;
          mid_message = 1;
        end
        if (!in_final_item) begin
          lanes = compress(lanes, in_message_word);
          byte_len = byte_len + 8'd8;
        end else begin
          total = byte_len + {5'd0, in_tail_count};
          mask = (64'd1 << (8 * in_tail_count)) - 64'd1;
          lanes = compress(lanes, {total, 56'd0} | (in_message_word & mask));
          lanes[2] = lanes[2] ^ FINAL_FLIP;
          repeat (4) lanes = mix_round(lanes);
          digest_q.push_back(lanes[0] ^ lanes[1] ^ lanes[2] ^ lanes[3]);
          mid_message = 0;
        end
      end

      if (out_pop && !out_empty) begin
        digest_count <= digest_count + 1;
        if (digest_q.size() == 0) begin
          fails++;
          if (shown < 10) begin
            shown++;
            $display("unexpected digest %h", out_digest);
          end
        end else begin
          if (digest_q[0] !== out_digest) begin
            fails++;
            if (shown < 10) begin
              shown++;
              $display("digest mismatch: expected %h got %h", digest_q[0], out_digest);
            end
          end
          void'(digest_q.pop_front());
        end
      end

      if (drain_done && !drained) begin
        drained = 1;
        if (digest_q.size() != 0) begin
          $display("%0d digests never arrived", digest_q.size());
          fails += digest_q.size();
        end
      end
    end
  end

endmodule

### tb/sv/siphash_2_4_keyed_hash_test.sv
`timescale 1ns / 100ps

module siphash_2_4_keyed_hash_test import sip_pkg::*;;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_wdata;
  logic        in_push;
  logic        in_full;
  logic [63:0] in_message_word;
  logic [2:0]  in_tail_count;
  logic        in_final_item;
  logic        out_empty;
  logic        out_pop;
  logic [63:0] out_digest;
  logic        drain_done;
  int          fail_count;
  int          digest_count;

  bit idling;
  bit sender_gaps;
  int words_sent;
  int finals_sent;
  int key_sets;
  int stall_left;

  siphash_2_4_keyed_hash dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_push(in_push), .in_full(in_full),
    .in_message_word(in_message_word), .in_tail_count(in_tail_count),
    .in_final_item(in_final_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_digest(out_digest)
  );

  siphash_2_4_keyed_hash_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_push(in_push), .in_full(in_full),
    .in_message_word(in_message_word), .in_tail_count(in_tail_count),
    .in_final_item(in_final_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_digest(out_digest),
    .drain_done(drain_done), .fail_count(fail_count), .digest_count(digest_count)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_pop <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_pop <= 0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_pop <= 0;
    end else begin
      out_pop <= 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(input logic [63:0] w, input logic [2:0] t, input logic f);
    in_message_word <= w;
    in_tail_count <= t;
    in_final_item <= f;
    in_push <= 1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    words_sent++;
    if (f) finals_sent++;
    if (idling && sender_gaps && $urandom_range(0, 3) == 0) begin
      in_push <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_message(input int nwords);
    sender_gaps = $urandom_range(0, 2) != 0;
    for (int i = 0; i < nwords; i++) send_word(rand64(), 3'($urandom), 1'b0);
    send_word(rand64(), 3'($urandom), 1'b1);
  endtask

  task automatic settle();
    in_push <= 0;
    for (int i = 0; i < 50000 && digest_count != finals_sent; i++) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_keys(input logic [63:0] k0, input logic [63:0] k1);
    cfg_we <= 1;
    cfg_index <= REG_KEY_LOW;
    cfg_wdata <= k0;
    @(posedge clk);
    cfg_index <= REG_KEY_HIGH;
    cfg_wdata <= k1;
    @(posedge clk);
    cfg_we <= 0;
    key_sets++;
  endtask

  initial begin
    int r;
    int target;
    logic [63:0] k0;
    logic [63:0] k1;
    rst_n <= 0;
    cfg_we <= 0;
    cfg_index <= REG_KEY_LOW;
    cfg_wdata <= '0;
    in_push <= 0;
    in_message_word <= '0;
    in_tail_count <= '0;
    in_final_item <= 0;
    drain_done <= 0;
    idling <= 1;
    sender_gaps = 1;
    words_sent = 0;
    finals_sent = 0;
    key_sets = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset key, empty message with junk in the ignored bytes
    send_word('1, 3'd0, 1'b1);
    settle();

    write_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    for (int t = 0; t < 8; t++) send_word(64'h0706050403020100, 3'(t), 1'b1);
    send_word(64'h0706050403020100, 3'd7, 1'b0);
    send_word(64'h0f0e0d0c0b0a0908, 3'd7, 1'b1);
    send_word('1, 3'd0, 1'b0);
    send_word('1, 3'd7, 1'b1);
    send_word('0, 3'd5, 1'b0);
    send_word('1, 3'd0, 1'b0);
    send_word('0, 3'd0, 1'b1);
    send_word(64'h8000000000000001, 3'd1, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin k0 = '1; k1 = '1; end
        1: begin k0 = '0; k1 = '1; end
        default: begin k0 = rand64(); k1 = rand64(); end
      endcase
      write_keys(k0, k1);
      if (phase == 3) idling <= 0;
      target = words_sent + 210;
      while (words_sent < target) begin
        r = $urandom_range(0, 19);
        if (r == 0) send_message($urandom_range(28, 40));
        else if (r < 4) send_message(0);
        else send_message($urandom_range(1, 6));
      end
    end

    settle();
    drain_done <= 1;
    repeat (2) @(posedge clk);
    $display("Hashed %0d messages in %0d words under %0d keys, idle gaps on both sides",
             finals_sent, words_sent, key_sets);
    $display("%0d digests compared, %0d failures", digest_count, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### siphash_2_4_keyed_hash.f
rtl/sip_pkg.sv
rtl/sip_queue.sv
rtl/sip_front.sv
rtl/sip_back.sv
rtl/siphash_2_4_keyed_hash.sv
tb/sv/siphash_2_4_keyed_hash_checker.sv
tb/sv/siphash_2_4_keyed_hash_test.sv
